[rtl/fss_pkg.sv]
// ----------------------------------------------------------------------------
// fss_pkg - furnace safety supervisor package
// types, codes and fixed thresholds used by the supervisor
// ----------------------------------------------------------------------------
package fss_pkg;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_RAMP     = 2'd1,
    MODE_SOAK     = 2'd2,
    MODE_COOL     = 2'd3
  } kiln_mode_e;

  typedef enum logic [3:0] {
    FAULT_NONE       = 4'd0,
    FAULT_PROGRAM    = 4'd1,
    FAULT_SENSOR     = 4'd2,
    FAULT_NO_RISE    = 4'd3,
    FAULT_RAMP_HARD  = 4'd4,
    FAULT_RAMP_OVER  = 4'd5,
    FAULT_SOAK_UNDER = 4'd6,
    FAULT_SOAK_OVER  = 4'd7,
    FAULT_COOL_UNDER = 4'd8,
    FAULT_COOL_RISE  = 4'd9
  } fault_code_e;

  typedef enum logic [2:0] {
    CFG_RAMP_OVER_TOL  = 3'd0,
    CFG_RAMP_HARD_STOP = 3'd1,
    CFG_SOAK_UNDER_TOL = 3'd2,
    CFG_SOAK_OVER_TOL  = 3'd3,
    CFG_SOAK_HARD_STOP = 3'd4,
    CFG_COOL_UNDER_TOL = 3'd5,
    CFG_NO_RISE_MIN    = 3'd6,
    CFG_COOL_RUN_RISE  = 3'd7
  } cfg_idx_e;

  localparam int NUM_CFG = 8;
  localparam int CFG_W   = 12;

  typedef logic [CFG_W-1:0] cfg_word_t;

  localparam cfg_word_t CFG_RESET [NUM_CFG] = '{
    12'd240, 12'd480, 12'd160, 12'd160, 12'd400, 12'd160, 12'd89, 12'd80
  };

  // debounce timer slots
  localparam int NUM_DB        = 7;
  localparam int DB_SENSOR     = 0;
  localparam int DB_RAMP_HARD  = 1;
  localparam int DB_RAMP_OVER  = 2;
  localparam int DB_SOAK_UNDER = 3;
  localparam int DB_SOAK_HARD  = 4;
  localparam int DB_SOAK_OVER  = 5;
  localparam int DB_COOL_UNDER = 6;

  localparam logic [31:0] DB_DURATION [NUM_DB] = '{
    32'd5000, 32'd0, 32'd300000, 32'd300000, 32'd0, 32'd120000, 32'd300000
  };

  localparam fault_code_e DB_FAULT [NUM_DB] = '{
    FAULT_SENSOR, FAULT_RAMP_HARD, FAULT_RAMP_OVER, FAULT_SOAK_UNDER,
    FAULT_SOAK_OVER, FAULT_SOAK_OVER, FAULT_COOL_UNDER
  };

  localparam logic signed [15:0] SENSOR_MIN = -16'sd800;
  localparam logic signed [15:0] SENSOR_MAX = 16'sd20800;

  localparam logic [9:0]  HEAT_DEMAND_PM    = 10'd800;
  localparam logic [9:0]  SOAK_DEMAND_PM    = 10'd700;
  localparam logic [9:0]  COOL_POWER_MAX_PM = 10'd50;
  localparam logic [31:0] HEAT_WINDOW_MS    = 32'd600000;
  localparam logic [31:0] COOL_WINDOW_MS    = 32'd180000;
  localparam logic [7:0]  HEAT_FAIL_REQ     = 8'd2;
  localparam logic [6:0]  JUMP_RATE_MUL     = 7'd75;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic [1:0]         kiln_mode;
    logic signed [15:0] temperature;
    logic               temperature_finite;
    logic signed [15:0] setpoint;
    logic [9:0]         heater_power;
    logic               program_ok;
  } sample_t;

endpackage

[rtl/fss_sample_if.sv]
// ----------------------------------------------------------------------------
// fss_sample_if - telemetry sample channel
// one beat carries one sample for the supervisor
// ----------------------------------------------------------------------------
interface fss_sample_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_ms;
  logic [1:0]         kiln_mode;
  logic signed [15:0] temperature;
  logic               temperature_finite;
  logic signed [15:0] setpoint;
  logic [9:0]         heater_power;
  logic               program_ok;

  modport source (
    output valid, now_ms, kiln_mode, temperature, temperature_finite,
           setpoint, heater_power, program_ok,
    input  ready
  );
  modport sink (
    input  valid, now_ms, kiln_mode, temperature, temperature_finite,
           setpoint, heater_power, program_ok,
    output ready
  );
endinterface

[rtl/fss_fault_if.sv]
// ----------------------------------------------------------------------------
// fss_fault_if - fault result channel
// one beat carries the fault code of one sample
// ----------------------------------------------------------------------------
interface fss_fault_if;
  logic       valid;
  logic       ready;
  logic [3:0] fault_code;

  modport source (output valid, fault_code, input ready);
  modport sink (input valid, fault_code, output ready);
endinterface

[rtl/fss_cfg_if.sv]
// ----------------------------------------------------------------------------
// fss_cfg_if - configuration write channel
// one beat writes one threshold register
// ----------------------------------------------------------------------------
interface fss_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/furnace_safety_supervisor.sv]
// ----------------------------------------------------------------------------
// furnace_safety_supervisor - telemetry safety checks for a kiln controller
// checks each sample in priority order and reports the first fault found
// ----------------------------------------------------------------------------
//
// channel   dir  beat
// sample_i  in   one telemetry sample (time, mode, temps, power, program flag)
// fault_o   out  one fault code per sample, 0 when all checks pass
// cfg_i     in   one 12-bit threshold write, index 0..7
//
// one sample per cycle sustained while fault_o is ready; a sample sits in
// the input register, then its fault code sits in the result register,
// which drives fault_o; the check chain and all state updates sit between
// those two registers
// reset loads the threshold defaults and clears all windows and timers
// a stalled result holds the result register; the input register keeps
// accepting until it too is full, then sample_i.ready drops
//
module furnace_safety_supervisor (
  input  logic clk_i,
  input  logic rst_ni,
  fss_sample_if.sink  sample_i,
  fss_fault_if.source fault_o,
  fss_cfg_if.sink     cfg_i
);
  import fss_pkg::*;

  // threshold registers
  cfg_word_t cfg_q [NUM_CFG];

  // input and result registers
  logic        in_valid_q;
  sample_t     in_q;
  logic        out_valid_q;
  fault_code_e out_code_q;

  // supervisor state
  logic               last_valid_q, last_valid_d;
  logic [31:0]        last_time_q, last_time_d;
  logic signed [15:0] last_temp_q, last_temp_d;
  logic               heat_active_q, heat_active_d;
  logic [31:0]        heat_time_q, heat_time_d;
  logic signed [15:0] heat_temp_q, heat_temp_d;
  logic [7:0]         heat_failed_q, heat_failed_d;
  logic [NUM_DB-1:0]  run_q, run_d;
  logic [31:0]        db_start_q [NUM_DB];
  logic [31:0]        db_start_d [NUM_DB];
  logic               cool_active_q, cool_active_d;
  logic [31:0]        cool_time_q, cool_time_d;
  logic signed [15:0] cool_temp_q, cool_temp_d;

  // handshake
  logic advance;
  logic sample_acc;

  assign advance    = in_valid_q && (!out_valid_q || fault_o.ready);
  assign sample_acc = sample_i.valid && sample_i.ready;

  assign sample_i.ready    = !in_valid_q || advance;
  assign fault_o.valid     = out_valid_q;
  assign fault_o.fault_code = out_code_q;
  assign cfg_i.ready       = 1'b1;

  // signed over/deficit against an unsigned threshold
  function automatic logic sge(logic signed [16:0] a, cfg_word_t b);
    return a >= $signed({5'd0, b});
  endfunction

  // decoded sample
  kiln_mode_e         mode;
  logic               fin;
  logic signed [16:0] over;
  logic signed [16:0] deficit;
  logic signed [16:0] jump;
  logic [15:0]        jump_abs;
  logic [22:0]        jump_scaled;
  logic [31:0]        jump_dt;
  logic               jump_bad;
  logic               invalid;
  logic signed [16:0] heat_rise;
  logic signed [16:0] cool_rise;
  logic [31:0]        heat_elapsed;
  logic [31:0]        cool_elapsed;
  logic [31:0]        db_elapsed [NUM_DB];
  logic [NUM_DB-1:0]  cond;
  logic [NUM_DB-1:0]  fire;
  fault_code_e        fault;
  logic               stop;

  assign mode    = kiln_mode_e'(in_q.kiln_mode);
  assign fin     = in_q.temperature_finite;
  assign over    = {in_q.temperature[15], in_q.temperature}
                 - {in_q.setpoint[15], in_q.setpoint};
  assign deficit = {in_q.setpoint[15], in_q.setpoint}
                 - {in_q.temperature[15], in_q.temperature};

  // jump rate: |dT| * 75 > 2 * dt, cross-multiplied
  assign jump        = {in_q.temperature[15], in_q.temperature}
                     - {last_temp_q[15], last_temp_q};
  assign jump_abs    = jump[16] ? 16'(-jump) : jump[15:0];
  assign jump_scaled = 23'(jump_abs) * 23'(JUMP_RATE_MUL);
  assign jump_dt     = in_q.now_ms - last_time_q;
  assign jump_bad    = fin && last_valid_q && (in_q.now_ms > last_time_q)
                    && ({10'd0, jump_scaled} > {jump_dt, 1'b0});

  assign invalid = !fin || (in_q.temperature < SENSOR_MIN)
                || (in_q.temperature > SENSOR_MAX) || jump_bad;

  assign heat_rise    = {in_q.temperature[15], in_q.temperature}
                      - {heat_temp_q[15], heat_temp_q};
  assign cool_rise    = {in_q.temperature[15], in_q.temperature}
                      - {cool_temp_q[15], cool_temp_q};
  assign heat_elapsed = in_q.now_ms - heat_time_q;
  assign cool_elapsed = in_q.now_ms - cool_time_q;

  // debounce conditions, one per timer
  assign cond[DB_SENSOR]     = invalid;
  assign cond[DB_RAMP_HARD]  = (mode == MODE_RAMP) && fin
                            && sge(over, cfg_q[CFG_RAMP_HARD_STOP]);
  assign cond[DB_RAMP_OVER]  = (mode == MODE_RAMP) && fin
                            && sge(over, cfg_q[CFG_RAMP_OVER_TOL]);
  assign cond[DB_SOAK_UNDER] = (mode == MODE_SOAK) && fin
                            && sge(deficit, cfg_q[CFG_SOAK_UNDER_TOL])
                            && (in_q.heater_power >= SOAK_DEMAND_PM);
  assign cond[DB_SOAK_HARD]  = (mode == MODE_SOAK) && fin
                            && sge(over, cfg_q[CFG_SOAK_HARD_STOP]);
  assign cond[DB_SOAK_OVER]  = (mode == MODE_SOAK) && fin
                            && sge(over, cfg_q[CFG_SOAK_OVER_TOL]);
  assign cond[DB_COOL_UNDER] = (mode == MODE_COOL) && fin
                            && sge(deficit, cfg_q[CFG_COOL_UNDER_TOL]);

  // a timer that starts on this sample has zero elapsed time
  for (genvar g = 0; g < NUM_DB; g++) begin : g_db
    assign db_elapsed[g] = in_q.now_ms - db_start_q[g];
    assign fire[g] = cond[g] && (run_q[g] ? (db_elapsed[g] >= DB_DURATION[g])
                                          : (DB_DURATION[g] == 32'd0));
  end

  // check chain in priority order; a fault stops all later updates
  always_comb begin
    last_valid_d  = last_valid_q;
    last_time_d   = last_time_q;
    last_temp_d   = last_temp_q;
    heat_active_d = heat_active_q;
    heat_time_d   = heat_time_q;
    heat_temp_d   = heat_temp_q;
    heat_failed_d = heat_failed_q;
    run_d         = run_q;
    db_start_d    = db_start_q;
    cool_active_d = cool_active_q;
    cool_time_d   = cool_time_q;
    cool_temp_d   = cool_temp_q;
    fault         = FAULT_NONE;
    stop          = 1'b0;

    if (mode == MODE_INACTIVE) begin
      // inactive clears every window, timer and the last sample
      last_valid_d  = 1'b0;
      last_time_d   = '0;
      last_temp_d   = '0;
      heat_active_d = 1'b0;
      heat_time_d   = '0;
      heat_temp_d   = '0;
      heat_failed_d = '0;
      run_d         = '0;
      for (int i = 0; i < NUM_DB; i++) db_start_d[i] = '0;
      cool_active_d = 1'b0;
      cool_time_d   = '0;
      cool_temp_d   = '0;
      stop          = 1'b1;
    end else if (!in_q.program_ok) begin
      fault = FAULT_PROGRAM;
      stop  = 1'b1;
    end else begin
      // sensor debounce; a sensor fault keeps the old last sample
      run_d[DB_SENSOR] = cond[DB_SENSOR];
      if (cond[DB_SENSOR] && !run_q[DB_SENSOR]) db_start_d[DB_SENSOR] = in_q.now_ms;
      if (fire[DB_SENSOR]) begin
        fault = FAULT_SENSOR;
        stop  = 1'b1;
      end

      if (!stop) begin
        last_temp_d  = in_q.temperature;
        last_time_d  = in_q.now_ms;
        last_valid_d = fin;

        // heat demand with no rise
        if ((mode == MODE_RAMP) && (in_q.heater_power >= HEAT_DEMAND_PM)) begin
          if (!heat_active_q) begin
            heat_active_d = 1'b1;
            heat_time_d   = in_q.now_ms;
            heat_temp_d   = in_q.temperature;
          end else if (heat_elapsed >= HEAT_WINDOW_MS) begin
            if (fin && !sge(heat_rise, cfg_q[CFG_NO_RISE_MIN])) begin
              if (heat_failed_q != 8'hFF) heat_failed_d = heat_failed_q + 8'd1;
            end else begin
              heat_failed_d = '0;
            end
            heat_time_d = in_q.now_ms;
            heat_temp_d = in_q.temperature;
          end
          if (heat_failed_d >= HEAT_FAIL_REQ) begin
            fault = FAULT_NO_RISE;
            stop  = 1'b1;
          end
        end else begin
          heat_active_d = 1'b0;
          heat_failed_d = '0;
        end
      end

      // remaining debounced checks, in order
      for (int i = DB_RAMP_HARD; i < NUM_DB; i++) begin
        if (!stop) begin
          run_d[i] = cond[i];
          if (cond[i] && !run_q[i]) db_start_d[i] = in_q.now_ms;
          if (fire[i]) begin
            fault = DB_FAULT[i];
            stop  = 1'b1;
          end
        end
      end

      // cooling runaway at low power
      if (!stop) begin
        if ((mode == MODE_COOL) && (in_q.heater_power <= COOL_POWER_MAX_PM)) begin
          if (!cool_active_q) begin
            cool_active_d = 1'b1;
            cool_time_d   = in_q.now_ms;
            cool_temp_d   = in_q.temperature;
          end else if (cool_elapsed >= COOL_WINDOW_MS) begin
            if (fin && sge(cool_rise, cfg_q[CFG_COOL_RUN_RISE])) begin
              fault = FAULT_COOL_RISE;
            end else begin
              cool_time_d = in_q.now_ms;
              cool_temp_d = in_q.temperature;
            end
          end
        end else begin
          cool_active_d = 1'b0;
        end
      end
    end
  end

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG; i++) cfg_q[i] <= CFG_RESET[i];
    end else if (cfg_i.valid && cfg_i.ready) begin
      cfg_q[cfg_i.index] <= cfg_i.data;
    end
  end

  // input and result valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sample_acc) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (fault_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      in_q.now_ms             <= sample_i.now_ms;
      in_q.kiln_mode          <= sample_i.kiln_mode;
      in_q.temperature        <= sample_i.temperature;
      in_q.temperature_finite <= sample_i.temperature_finite;
      in_q.setpoint           <= sample_i.setpoint;
      in_q.heater_power       <= sample_i.heater_power;
      in_q.program_ok         <= sample_i.program_ok;
    end
    if (advance) out_code_q <= fault;
  end

  // supervisor state, committed as the sample moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_valid_q  <= 1'b0;
      last_time_q   <= '0;
      last_temp_q   <= '0;
      heat_active_q <= 1'b0;
      heat_time_q   <= '0;
      heat_temp_q   <= '0;
      heat_failed_q <= '0;
      run_q         <= '0;
      for (int i = 0; i < NUM_DB; i++) db_start_q[i] <= '0;
      cool_active_q <= 1'b0;
      cool_time_q   <= '0;
      cool_temp_q   <= '0;
    end else if (advance) begin
      last_valid_q  <= last_valid_d;
      last_time_q   <= last_time_d;
      last_temp_q   <= last_temp_d;
      heat_active_q <= heat_active_d;
      heat_time_q   <= heat_time_d;
      heat_temp_q   <= heat_temp_d;
      heat_failed_q <= heat_failed_d;
      run_q         <= run_d;
      db_start_q    <= db_start_d;
      cool_active_q <= cool_active_d;
      cool_time_q   <= cool_time_d;
      cool_temp_q   <= cool_temp_d;
    end
  end

  // failed-window count only lives inside an open heat window
  a_heat_count_in_window : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (heat_failed_q != 8'd0) |-> heat_active_q
  ) else $error("heat fail count set with no heat window");

  // a full input register that cannot move on must refuse a new sample
  a_no_overrun : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |-> !sample_i.ready
  ) else $error("sample accepted over a held one");

  // an inactive sample leaves every window and timer cleared
  a_inactive_clears : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && (mode == MODE_INACTIVE)) |=>
      (run_q == '0) && !last_valid_q && !heat_active_q && !cool_active_q
  ) else $error("inactive sample left state behind");

  // an inactive sample always reports no fault
  a_inactive_no_fault : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && (mode == MODE_INACTIVE)) |=> (out_code_q == FAULT_NONE)
  ) else $error("fault reported for inactive sample");

endmodule
